>>> rtl/core/swlp_pkg.sv
// Shared types and constants of the sliding-window line predictor.
`default_nettype none
package swlp_pkg;

	// Window length; the sums divide by it through shifts, so it stays a power of two.
	localparam int LogWindow = 4;
	localparam int Window    = 1 << LogWindow;
	localparam int SlotW     = LogWindow;
	localparam int FillW     = LogWindow + 1;

	// Running sum widths for a window of sixteen 16-bit samples.
	localparam int StW   = 20;
	localparam int SttW  = 36;
	localparam int SvW   = 21;
	localparam int ScW   = 37;
	localparam int NumW  = 42;
	localparam int DenW  = 41;
	localparam int DW    = 22;
	localparam int ProdW = 66;
	localparam int SerW  = 22;
	localparam int DivisorW = DenW + LogWindow;
	localparam int MulSteps = SerW;
	localparam int DivSteps = ProdW;

	typedef enum logic {
		OP_OBSERVE = 1'b0,
		OP_PREDICT = 1'b1
	} op_kind_t;

	typedef struct packed {
		op_kind_t           kind;
		logic [15:0]        t;
		logic signed [15:0] v;
	} work_t;

	typedef struct packed {
		logic  valid;
		work_t word;
	} queue_head_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_OBS_MUL,
		ST_OBS_UPD,
		ST_MUL,
		ST_SPREAD,
		ST_EVAL,
		ST_SUM,
		ST_DIV
	} seq_state_t;

	typedef enum logic [1:0] {
		PR_ST_SV,
		PR_ST_ST,
		PR_SV_DEN,
		PR_NUM_D
	} prod_sel_t;

endpackage
`default_nettype wire

>>> rtl/core/swlp_in_if.sv
// Input channel of the line predictor: one sample or query word.
`default_nettype none
interface swlp_in_if;
	logic               valid;
	logic               ready;
	logic               op;
	logic [15:0]        sample_time;
	logic signed [15:0] sample_value;

	modport source(output valid, output op, output sample_time, output sample_value,
		input ready);
	modport sink(input valid, input op, input sample_time, input sample_value,
		output ready);
endinterface
`default_nettype wire

>>> rtl/core/swlp_out_if.sv
// Output channel of the line predictor: one result word.
`default_nettype none
interface swlp_out_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] prediction;
	logic               prediction_valid;
	logic               trained;
	logic               steep;

	modport source(output valid, output prediction, output prediction_valid,
		output trained, output steep, input ready);
	modport sink(input valid, input prediction, input prediction_valid,
		input trained, input steep, output ready);
endinterface
`default_nettype wire

>>> rtl/core/swlp_front.sv
// Front end: accepts words, classifies them and holds them in a two-entry queue.
`default_nettype none
module swlp_front (
	input  logic                  clk,
	input  logic                  arst_n,
	swlp_in_if.sink               in_ch,
	input  logic                  pop,
	output swlp_pkg::queue_head_t head
);
	import swlp_pkg::*;

	work_t      mem_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] cnt_q;
	logic       push;
	logic       do_pop;
	work_t      word_in;

	assign in_ch.ready = (cnt_q != 2'd2);
	assign push        = in_ch.valid && in_ch.ready;
	assign do_pop      = pop && (cnt_q != 2'd0);

	always_comb begin
		word_in.t    = in_ch.sample_time;
		word_in.kind = in_ch.op ? OP_PREDICT : OP_OBSERVE;
		// value is meaningless on a query
		word_in.v    = in_ch.op ? 16'sd0 : in_ch.sample_value;
	end

	assign head.valid = (cnt_q != 2'd0);
	assign head.word  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= word_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push) wr_ptr_q <= ~wr_ptr_q;
			if (do_pop) rd_ptr_q <= ~rd_ptr_q;
			case ({push, do_pop})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end
endmodule
`default_nettype wire

>>> rtl/core/swlp_div.sv
// Restoring divider, one quotient bit per cycle.
`default_nettype none
module swlp_div (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	input  logic [swlp_pkg::ProdW-1:0]        dividend,
	input  logic [swlp_pkg::DivisorW-1:0]     divisor,
	output logic                              done,
	output logic [swlp_pkg::ProdW-1:0]        quotient
);
	import swlp_pkg::*;

	logic                busy_q;
	logic [6:0]          cnt_q;
	logic [DivisorW-1:0] rem_q;
	logic [DivisorW-1:0] dvs_q;
	logic [ProdW-1:0]    quo_q;
	logic [DivisorW:0]   trial;
	logic [DivisorW:0]   diff;
	logic                ge;

	assign trial    = {rem_q, quo_q[ProdW-1]};
	assign ge       = trial >= {1'b0, dvs_q};
	assign diff     = trial - {1'b0, dvs_q};
	assign done     = busy_q && (cnt_q == 7'(DivSteps - 1));
	assign quotient = {quo_q[ProdW-2:0], ge};

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			dvs_q <= divisor;
		end else if (busy_q) begin
			rem_q <= ge ? diff[DivisorW-1:0] : trial[DivisorW-1:0];
			quo_q <= {quo_q[ProdW-2:0], ge};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 7'd1;
			if (done) busy_q <= 1'b0;
		end
	end
endmodule
`default_nettype wire

>>> rtl/core/swlp_back.sv
// Back end: sample rings, window sums, shift-add multiplier and prediction sequencer.
`default_nettype none
module swlp_back (
	input  logic                  clk,
	input  logic                  arst_n,
	input  swlp_pkg::queue_head_t head,
	output logic                  pop,
	swlp_out_if.source            out_ch
);
	import swlp_pkg::*;

	seq_state_t state_q, state_d;
	prod_sel_t  sel_q, ld_sel;
	logic       mul_load;

	logic [15:0]        time_ring_q  [Window];
	logic signed [15:0] value_ring_q [Window];
	logic [SlotW-1:0]   slot_q;
	logic [FillW-1:0]   fill_q, fill_nxt;
	logic [StW-1:0]     st_q;
	logic [SttW-1:0]    stt_q;
	logic signed [SvW-1:0] sv_q;
	logic signed [ScW-1:0] sc_q;
	work_t              item_q;

	logic [15:0]        ot_s1;
	logic signed [15:0] ov_s1;
	logic [31:0]        tt_s1, ott_s1;
	logic signed [31:0] tv_s1, otv_s1;
	logic signed [32:0] tv_full, otv_full;

	logic [ProdW-1:0]   mcand_q, acc_q, acc_step, prod;
	logic [SerW-1:0]    mplier_q;
	logic               mneg_q;
	logic [4:0]         mcnt_q;
	logic               mul_last;
	logic signed [ProdW-1:0] mul_a, a_mag;
	logic signed [SerW-1:0]  mul_b, b_mag;

	logic signed [ProdW-1:0] p0_q, p1_q, p2_q, p3_q;
	logic signed [NumW-1:0]  num_q;
	logic [DenW-1:0]         den_q;
	logic signed [DW-1:0]    d_q;

	logic signed [ProdW-1:0] total;
	logic                    tneg_q;
	logic                    div_start, div_done;
	logic [ProdW-1:0]        div_quo, limit, qm;
	logic [DivisorW-1:0]     divisor;

	logic signed [SvW:0]     sv_round;
	logic signed [31:0]      mean_y;

	logic               res_valid_q;
	logic signed [31:0] res_pred_q;
	logic               res_pv_q, res_trained_q, res_steep_q;

	assign out_ch.valid            = res_valid_q;
	assign out_ch.prediction       = res_pred_q;
	assign out_ch.prediction_valid = res_pv_q;
	assign out_ch.trained          = res_trained_q;
	assign out_ch.steep            = res_steep_q;

	assign mul_last = (mcnt_q == 5'(MulSteps - 1));
	assign fill_nxt = (fill_q < FillW'(Window)) ? fill_q + 1'b1 : fill_q;

	// sum_value / Window, rounded toward zero
	assign sv_round = {sv_q[SvW-1], sv_q} + (sv_q[SvW-1] ? (SvW+1)'(Window - 1) : '0);
	assign mean_y   = 32'(sv_round >>> LogWindow);

	always_comb begin
		state_d  = state_q;
		pop      = 1'b0;
		mul_load = 1'b0;
		ld_sel   = PR_ST_SV;
		div_start = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (head.valid && !res_valid_q) begin
					pop = 1'b1;
					if (head.word.kind == OP_OBSERVE) begin
						state_d = ST_OBS_MUL;
					end else begin
						state_d  = ST_MUL;
						mul_load = 1'b1;
						ld_sel   = PR_ST_SV;
					end
				end
			end
			ST_OBS_MUL: state_d = ST_OBS_UPD;
			ST_OBS_UPD: state_d = ST_IDLE;
			ST_MUL: begin
				if (mul_last) begin
					case (sel_q)
						PR_ST_SV: begin
							mul_load = 1'b1;
							ld_sel   = PR_ST_ST;
						end
						PR_ST_ST: state_d = ST_SPREAD;
						PR_SV_DEN: begin
							mul_load = 1'b1;
							ld_sel   = PR_NUM_D;
						end
						default: state_d = ST_SUM;
					endcase
				end
			end
			ST_SPREAD: state_d = ST_EVAL;
			ST_EVAL: begin
				if (num_q == '0 || den_q == '0) begin
					state_d = ST_IDLE;
				end else begin
					state_d  = ST_MUL;
					mul_load = 1'b1;
					ld_sel   = PR_SV_DEN;
				end
			end
			ST_SUM: begin
				div_start = 1'b1;
				state_d   = ST_DIV;
			end
			ST_DIV: begin
				if (div_done) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_IDLE;
		else state_q <= state_d;
	end

	// multiplier operand select; signed-magnitude shift-add over the serial operand
	always_comb begin
		case (ld_sel)
			PR_ST_SV: begin
				mul_a = $signed({{(ProdW-StW){1'b0}}, st_q});
				mul_b = $signed({sv_q[SvW-1], sv_q});
			end
			PR_ST_ST: begin
				mul_a = $signed({{(ProdW-StW){1'b0}}, st_q});
				mul_b = $signed({{(SerW-StW){1'b0}}, st_q});
			end
			PR_SV_DEN: begin
				mul_a = $signed({{(ProdW-DenW){1'b0}}, den_q});
				mul_b = $signed({sv_q[SvW-1], sv_q});
			end
			default: begin
				mul_a = $signed({{(ProdW-NumW){num_q[NumW-1]}}, num_q});
				mul_b = d_q;
			end
		endcase
		a_mag = mul_a[ProdW-1] ? -mul_a : mul_a;
		b_mag = mul_b[SerW-1] ? -mul_b : mul_b;
	end

	assign acc_step = mplier_q[0] ? acc_q + mcand_q : acc_q;
	assign prod     = mneg_q ? -acc_step : acc_step;

	assign total   = p2_q + p3_q;
	assign divisor = {den_q, {LogWindow{1'b0}}};
	assign limit   = tneg_q ? ProdW'(64'h8000_0000) : ProdW'(64'h7FFF_FFFF);
	assign qm      = (div_quo > limit) ? limit : div_quo;

	assign tv_full  = $signed({1'b0, item_q.t}) * item_q.v;
	assign otv_full = $signed({1'b0, time_ring_q[slot_q]}) * value_ring_q[slot_q];

	// magnitude of the sum goes in at start; its sign is kept in tneg_q
	swlp_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (total[ProdW-1] ? ProdW'(-total) : ProdW'(total)),
		.divisor  (divisor),
		.done     (div_done),
		.quotient (div_quo)
	);

	// datapath registers without reset
	always_ff @(posedge clk) begin
		if (pop) item_q <= head.word;
		if (state_q == ST_OBS_MUL) begin
			ot_s1  <= time_ring_q[slot_q];
			ov_s1  <= value_ring_q[slot_q];
			tt_s1  <= item_q.t * item_q.t;
			ott_s1 <= time_ring_q[slot_q] * time_ring_q[slot_q];
			tv_s1  <= tv_full[31:0];
			otv_s1 <= otv_full[31:0];
		end
		if (mul_load) begin
			sel_q    <= ld_sel;
			mcand_q  <= ProdW'(a_mag);
			mplier_q <= SerW'(b_mag);
			acc_q    <= '0;
			mneg_q   <= mul_a[ProdW-1] ^ mul_b[SerW-1];
			mcnt_q   <= '0;
		end else if (state_q == ST_MUL) begin
			mcand_q  <= {mcand_q[ProdW-2:0], 1'b0};
			mplier_q <= {1'b0, mplier_q[SerW-1:1]};
			acc_q    <= acc_step;
			mcnt_q   <= mcnt_q + 5'd1;
		end
		if (state_q == ST_MUL && mul_last) begin
			case (sel_q)
				PR_ST_SV:  p0_q <= prod;
				PR_ST_ST:  p1_q <= prod;
				PR_SV_DEN: p2_q <= prod;
				default:   p3_q <= prod;
			endcase
		end
		if (state_q == ST_SPREAD) begin
			num_q <= {sc_q[ScW-1], sc_q, {LogWindow{1'b0}}} - p0_q[NumW-1:0];
			den_q <= {1'b0, stt_q, {LogWindow{1'b0}}} - p1_q[DenW-1:0];
			d_q   <= $signed({2'b00, item_q.t, {LogWindow{1'b0}}}) -
				$signed({{(DW-StW){1'b0}}, st_q});
		end
		if (state_q == ST_SUM) tneg_q <= total[ProdW-1];
		if (state_q == ST_OBS_UPD) begin
			res_pred_q    <= '0;
			res_pv_q      <= 1'b0;
			res_trained_q <= (fill_nxt >= FillW'(Window));
			res_steep_q   <= 1'b0;
		end else if (state_q == ST_EVAL && (num_q == '0 || den_q == '0)) begin
			res_pv_q      <= 1'b1;
			res_trained_q <= (fill_q >= FillW'(Window));
			if (num_q == '0) begin
				res_pred_q  <= mean_y;
				res_steep_q <= 1'b0;
			end else begin
				res_steep_q <= 1'b1;
				if (d_q > 0) res_pred_q <= 32'sh7FFF_FFFF;
				else if (d_q < 0) res_pred_q <= 32'sh8000_0000;
				else res_pred_q <= mean_y;
			end
		end else if (state_q == ST_DIV && div_done) begin
			res_pv_q      <= 1'b1;
			res_trained_q <= (fill_q >= FillW'(Window));
			res_steep_q   <= 1'b0;
			res_pred_q    <= tneg_q ? -$signed(qm[31:0]) : $signed(qm[31:0]);
		end
	end

	// sample state and result handshake
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < Window; i++) begin
				time_ring_q[i]  <= '0;
				value_ring_q[i] <= '0;
			end
			slot_q      <= '0;
			fill_q      <= '0;
			st_q        <= '0;
			stt_q       <= '0;
			sv_q        <= '0;
			sc_q        <= '0;
			res_valid_q <= 1'b0;
		end else begin
			if (state_q == ST_OBS_UPD) begin
				st_q  <= st_q + StW'(item_q.t) - StW'(ot_s1);
				stt_q <= stt_q + SttW'(tt_s1) - SttW'(ott_s1);
				sv_q  <= sv_q + {{(SvW-16){item_q.v[15]}}, item_q.v} -
					{{(SvW-16){ov_s1[15]}}, ov_s1};
				sc_q  <= sc_q + {{(ScW-32){tv_s1[31]}}, tv_s1} -
					{{(ScW-32){otv_s1[31]}}, otv_s1};
				time_ring_q[slot_q]  <= item_q.t;
				value_ring_q[slot_q] <= item_q.v;
				slot_q <= (slot_q == SlotW'(Window - 1)) ? '0 : slot_q + 1'b1;
				fill_q <= fill_nxt;
			end
			if ((state_q == ST_OBS_UPD) ||
				(state_q == ST_EVAL && (num_q == '0 || den_q == '0)) ||
				(state_q == ST_DIV && div_done)) begin
				res_valid_q <= 1'b1;
			end else if (out_ch.ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end
endmodule
`default_nettype wire

>>> rtl/core/sliding_window_line_predictor_unit.sv
// Top level of the sliding-window least-squares line predictor.
`default_nettype none
// Keeps the last 16 (time, value) samples and exact window sums of t, t*t, v and t*v.
// Each input word gives exactly one result word. An observe word (op = 0) replaces the
// oldest sample. A predict word (op = 1) evaluates the least-squares line at
// sample_time: four signed products on one shared shift-add multiplier, then a
// restoring divider at one quotient bit per cycle; a predict whose numerator or spread
// is zero finishes after the first two products. The result is rounded toward zero
// and saturated to 32 bits; steep flags a zero time spread with a nonzero numerator.
// A two-word queue between the front end and the back end keeps the input open for up
// to two words while a prediction is being worked out, and the result register holds
// its word until the sink takes it.
module sliding_window_line_predictor_unit (
	input  logic       clk,
	input  logic       arst_n,
	swlp_in_if.sink    in_ch,
	swlp_out_if.source out_ch
);
	import swlp_pkg::*;

	queue_head_t head;   // oldest queued word
	logic        pop;    // back end takes it

	swlp_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch),
		.pop    (pop),
		.head   (head)
	);

	swlp_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.head   (head),
		.pop    (pop),
		.out_ch (out_ch)
	);
endmodule
`default_nettype wire

>>> test/tb_sliding_window_line_predictor_unit.sv
// Self-checking testbench of the sliding-window line predictor.
`timescale 1ns / 100ps
module tb_sliding_window_line_predictor_unit;
	import swlp_pkg::*;

	typedef struct {
		logic signed [31:0] prediction;
		logic               prediction_valid;
		logic               trained;
		logic               steep;
	} line_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	swlp_in_if  in_ch();
	swlp_out_if out_ch();

	sliding_window_line_predictor_unit uut (
		.clk(clk),
		.arst_n(arst_n),
		.in_ch(in_ch),
		.out_ch(out_ch)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Predictor state: the window as the block holds it, with exact sums.
	logic [15:0]        win_time [Window];
	logic signed [15:0] win_value [Window];
	longint             acc_t, acc_tt, acc_v, acc_tv;
	int                 next_slot, filled;

	line_result_t expected_lines[$];
	int errors = 0;
	int words_sent = 0;
	int predicts_sent = 0;
	int words_seen = 0;
	bit sink_stall_off = 0;

	task automatic report_mismatch(input string what, input longint got, input longint want);
		$display("MISMATCH word %0d %s: got %0d want %0d", words_seen, what, got, want);
		errors++;
	endtask

	function automatic void clear_window();
		for (int i = 0; i < Window; i++) begin
			win_time[i] = '0;
			win_value[i] = '0;
		end
		acc_t = 0; acc_tt = 0; acc_v = 0; acc_tv = 0;
		next_slot = 0;
		filled = 0;
	endfunction

	// Updates the window on an observe, else the least-squares line value at query time t; 128-bit exact arithmetic.
	function automatic line_result_t fit_line(input op_kind_t kind, input logic [15:0] t,
		input logic signed [15:0] v);
		line_result_t r;
		longint tq, vq, ot, ov, num, den, d, nden;
		logic signed [127:0] total, mag, quo;
		bit neg;
		r = '{0, 0, 0, 0};
		tq = longint'(t);
		vq = longint'(v);
		if (kind == OP_OBSERVE) begin
			ot = longint'(win_time[next_slot]);
			ov = longint'(win_value[next_slot]);
			acc_t += tq - ot;
			acc_tt += tq * tq - ot * ot;
			acc_v += vq - ov;
			acc_tv += tq * vq - ot * ov;
			win_time[next_slot] = t;
			win_value[next_slot] = v;
			next_slot = (next_slot + 1) % Window;
			if (filled < Window) filled++;
		end else begin
			r.prediction_valid = 1'b1;
			num = Window * acc_tv - acc_t * acc_v;
			den = Window * acc_tt - acc_t * acc_t;
			d = Window * tq - acc_t;
			if (num == 0) begin
				r.prediction = 32'(acc_v / Window);
			end else if (den == 0) begin
				// zero spread: slope taken as infinite
				r.steep = 1'b1;
				if (d > 0) r.prediction = 32'h7fffffff;
				else if (d < 0) r.prediction = 32'h80000000;
				else r.prediction = 32'(acc_v / Window);
			end else begin
				nden = Window * den;
				total = 128'(signed'(acc_v)) * 128'(signed'(den))
					+ 128'(signed'(num)) * 128'(signed'(d));
				neg = total < 0;
				mag = neg ? -total : total;
				quo = mag / 128'(signed'(nden));
				if (neg) r.prediction = (quo > 128'sh80000000) ? 32'h80000000 : 32'(-quo);
				else r.prediction = (quo > 128'sh7fffffff) ? 32'h7fffffff : 32'(quo);
			end
		end
		r.trained = filled >= Window;
		return r;
	endfunction

	// Short gaps mostly, an occasional long one.
	function automatic int gap_len();
		int p;
		p = $urandom_range(99);
		if (p < 55) return 0;
		if (p < 92) return $urandom_range(3, 1);
		return $urandom_range(200, 20);
	endfunction

	task automatic send_word(input op_kind_t kind, input logic [15:0] t,
		input logic signed [15:0] v);
		in_ch.valid <= 1'b1;
		in_ch.op <= kind;
		in_ch.sample_time <= t;
		in_ch.sample_value <= v;
		@(posedge clk);
		while (!in_ch.ready) @(posedge clk);
		expected_lines.push_back(fit_line(kind, t, v));
		words_sent++;
		if (kind == OP_PREDICT) predicts_sent++;
		if (!sink_stall_off) begin
			int g;
			g = gap_len();
			if (g > 0) begin
				in_ch.valid <= 1'b0;
				repeat (g) @(posedge clk);
			end
		end
	endtask

	task automatic idle_input();
		in_ch.valid <= 1'b0;
		@(posedge clk);
	endtask

	// Result side: random stall, then check the word against the oldest expectation.
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_ch.valid && out_ch.ready) begin
				line_result_t e;
				words_seen++;
				if (expected_lines.size() == 0) begin
					report_mismatch("unexpected word", 1, 0);
				end else begin
					e = expected_lines.pop_front();
					if (out_ch.prediction !== e.prediction)
						report_mismatch("prediction", out_ch.prediction, e.prediction);
					if (out_ch.prediction_valid !== e.prediction_valid)
						report_mismatch("prediction_valid", out_ch.prediction_valid,
							e.prediction_valid);
					if (out_ch.trained !== e.trained)
						report_mismatch("trained", out_ch.trained, e.trained);
					if (out_ch.steep !== e.steep)
						report_mismatch("steep", out_ch.steep, e.steep);
				end
			end
			out_ch.ready <= sink_stall_off ? 1'b1 : ($urandom_range(99) < 60);
		end
	end

	task automatic test_cold_predicts();
		// empty window: all sums zero, then a single sample at the extremes
		send_word(OP_PREDICT, 16'h0000, 16'sh0000);
		send_word(OP_PREDICT, 16'hffff, 16'sh7fff);
		send_word(OP_OBSERVE, 16'hffff, 16'sh7fff);
		send_word(OP_PREDICT, 16'hffff, 16'sh0000);
		send_word(OP_PREDICT, 16'h0000, 16'sh0000);
	endtask

	task automatic test_field_extremes();
		// fill the window with steep extreme points, wrap the ring, and query both ends and the middle
		for (int i = 0; i < 18; i++)
			send_word(OP_OBSERVE, (i % 2) ? 16'hffff : 16'h0000,
				(i % 2) ? 16'sh8000 : 16'sh7fff);
		send_word(OP_PREDICT, 16'h0000, 16'sh0000);
		send_word(OP_PREDICT, 16'hffff, 16'sh8000);
		send_word(OP_PREDICT, 16'h7fff, 16'sh0000);
	endtask

	task automatic test_flat_and_single_time();
		// one time value everywhere: zero spread, zero numerator
		for (int i = 0; i < Window; i++) send_word(OP_OBSERVE, 16'd1000, 16'sh8000);
		send_word(OP_PREDICT, 16'd5, 16'sh0000);
		// constant value: zero slope
		for (int i = 0; i < Window; i++) send_word(OP_OBSERVE, 16'(i * 3), -16'sd5);
		send_word(OP_PREDICT, 16'hffff, 16'sh0000);
	endtask

	task automatic test_random_tracks();
		int base, slope, noise;
		for (int k = 0; k < 1500; ) begin
			int mode;
			mode = $urandom_range(9);
			if (mode < 7) begin
				// a line with noise and a burst of queries, times random or in steps from a base
				base = $urandom_range(65535);
				slope = $urandom_range(40) - 20;
				noise = $urandom_range(64);
				for (int j = 0; j < $urandom_range(20, 4); j++, k++) begin
					int tt, vv;
					tt = (mode < 3) ? $urandom_range(65535) :
						(base + j * $urandom_range(50, 1)) & 16'hffff;
					vv = slope * j + $urandom_range(2 * noise) - noise;
					send_word(OP_OBSERVE, 16'(tt), 16'(vv));
				end
				for (int j = 0; j < $urandom_range(3, 1); j++, k++)
					send_word(OP_PREDICT, 16'($urandom_range(65535)), 16'($urandom));
			end else begin
				send_word(op_kind_t'($urandom_range(1)), 16'($urandom), 16'($urandom));
				k++;
			end
		end
	endtask

	task automatic test_steady_stream();
		// back-to-back words with the sink always ready
		sink_stall_off = 1;
		for (int i = 0; i < 40; i++)
			send_word(op_kind_t'(i % 4 == 3), 16'($urandom), 16'($urandom));
		sink_stall_off = 0;
	endtask

	initial begin
		in_ch.valid = 1'b0;
		in_ch.op = OP_OBSERVE;
		in_ch.sample_time = '0;
		in_ch.sample_value = '0;
		out_ch.ready = 1'b0;
		clear_window();
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_cold_predicts();
		test_field_extremes();
		test_flat_and_single_time();
		test_steady_stream();
		test_random_tracks();
		idle_input();
		while (expected_lines.size() != 0) @(posedge clk);
		repeat (200) @(posedge clk);
		$display("Covered %0d words (%0d predicts), %0d results checked.",
			words_sent, predicts_sent, words_seen);
		if (errors == 0)
			$display("tb_sliding_window_line_predictor_unit: done, clean");
		else
			$display("tb_sliding_window_line_predictor_unit: done, errors");
		$finish;
	end

	initial begin
		#40ms;
		$display("tb_sliding_window_line_predictor_unit: done, errors");
		$finish;
	end

endmodule
